FILE: rtl/windowed_response_bias_monitor_macros.svh
// ----------------------------------------------------------------------------
// Windowed response bias monitor assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RESPONSE_BIAS_MONITOR_MACROS_SVH
`define WINDOWED_RESPONSE_BIAS_MONITOR_MACROS_SVH

// Same-cycle implication.
`define WRBM_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WRBM_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wrbm_pkg.sv
// ----------------------------------------------------------------------------
// Windowed response bias monitor package
// Field widths, register indexes, command codes and the control state type.
// ----------------------------------------------------------------------------
package wrbm_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRACE_TRIALS  = 1'd1;

    // Register widths and reset values.
    localparam int WIN_LEN_W = 7;
    localparam int GRACE_W   = 16;
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = 7'd16;
    localparam logic [GRACE_W-1:0]   GRACE_RST   = 16'd16;

    // Input fields.
    localparam int CHOICE_W   = 8;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 1;
    localparam logic CMD_TRIAL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Output fields.
    localparam int FRAC_BITS   = 16;
    localparam int TASK_MEAN_W = 18;
    localparam int RESP_MEAN_W = 25;
    localparam int ALT_MEAN_W  = 25;
    localparam int M_TDATA_W   = 72;
    localparam int M_PAD_W     = M_TDATA_W - TASK_MEAN_W - RESP_MEAN_W - ALT_MEAN_W;

    // Trial counter.
    localparam int COUNT_W = 16;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVICT,
        ST_THRESH,
        ST_DIV
    } state_t;

endpackage

FILE: rtl/wrbm_div_lane.sv
// ----------------------------------------------------------------------------
// Windowed response bias monitor divider lane
// Bit-serial restoring divider: computes trunc(sum * 2^16 / len) for a
// signed sum, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrbm_div_lane #(
    parameter int MAG_W = 7,
    parameter int LEN_W = 7,
    parameter int Q_W   = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [LEN_W-1:0]        len,
    input  logic signed [MAG_W:0]   sum,
    output logic                    busy,
    output logic signed [Q_W-1:0]   quotient
);

    localparam int DW    = MAG_W + wrbm_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [DW-1:0]    shf_reg, shf_next;
    logic             neg_reg, neg_next;

    logic [MAG_W:0]   neg_sum;
    logic [MAG_W-1:0] mag;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;
    logic [Q_W-1:0]   q_mag;

    // Magnitude of the dividend.
    assign neg_sum = -sum;
    assign mag     = sum[MAG_W] ? neg_sum[MAG_W-1:0] : sum[MAG_W-1:0];

    // One restoring step: bring down the next dividend bit and try len.
    assign trial = {rem_reg, shf_reg[DW-1]};
    assign diff  = trial - {1'b0, len_reg};
    assign ge    = (trial >= {1'b0, len_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        shf_next  = shf_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            rem_next  = '0;
            len_next  = len;
            shf_next  = {mag, {wrbm_pkg::FRAC_BITS{1'b0}}};
            neg_next  = sum[MAG_W];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            shf_next = {shf_reg[DW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        len_reg <= len_next;
        shf_reg <= shf_next;
        neg_reg <= neg_next;
    end

    // The quotient register doubles as the shifted dividend; apply the sign.
    assign q_mag    = shf_reg[Q_W-1:0];
    assign quotient = neg_reg ? (~q_mag + 1'b1) : q_mag;
    assign busy     = busy_reg;

endmodule

FILE: rtl/windowed_response_bias_monitor.sv
// ----------------------------------------------------------------------------
// Windowed response bias monitor
// Keeps a sliding window of trial outcomes and responses, maintains running
// success, response and alternating-sign response sums, and reports each
// sum divided by the window length as signed fixed point (16 fraction bits).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   s_*     | in        | s_tvalid / s_tready  | s_tdata, s_tuser (command)
//   m_*     | out       | m_tvalid / m_tready  | m_tdata (three means)
//   cfg_*   | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
// A clear command is done in the idle state. A trial passes the check
// state, an evict and a check step for each window entry dropped (usually
// one) and the threshold state; when a result is due, the bit-serial
// dividers run and then the output register is loaded.
// The window memory needs no clearing pass; all control state resets at once.
// A stalled result sits in the output register while the next transaction
// is taken; only the final load waits for that register to drain.
// ----------------------------------------------------------------------------
module windowed_response_bias_monitor #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [wrbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wrbm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: success_flag [0], response_choice [8:1], zero [15:9]
    input  logic [wrbm_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: command [0]
    input  logic [wrbm_pkg::S_TUSER_W-1:0]      s_tuser,
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: task_mean [17:0], response_mean [42:18],
    //          alternation_mean [67:43], zero [71:68]
    output logic [wrbm_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int SS_W = CW + 1;
    localparam int RS_W = CW + wrbm_pkg::CHOICE_W + 1;
    localparam int LCW  = (CW > wrbm_pkg::WIN_LEN_W) ? CW : wrbm_pkg::WIN_LEN_W;
    localparam int ENT_W = wrbm_pkg::CHOICE_W + 1;

    // Configuration registers.
    logic [wrbm_pkg::WIN_LEN_W-1:0] win_len_reg;
    logic [wrbm_pkg::GRACE_W-1:0]   grace_reg;

    // Control and window state.
    wrbm_pkg::state_t                state_reg, state_next;
    logic [AW-1:0]                   oldest_reg, oldest_next;
    logic [AW-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]                   fill_reg, fill_next;
    logic [wrbm_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic signed [SS_W-1:0]          ssum_reg, ssum_next;
    logic signed [RS_W-1:0]          rsum_reg, rsum_next;
    logic signed [RS_W-1:0]          asum_reg, asum_next;

    // Latched trial payload.
    logic                            flag_reg, flag_next;
    logic [wrbm_pkg::CHOICE_W-1:0]   choice_reg, choice_next;

    // Window memory.
    logic [ENT_W-1:0]                win_mem [WINDOW_MAX];
    logic [ENT_W-1:0]                rd_data_reg;
    logic                            mem_we;
    logic                            mem_re;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    logic [wrbm_pkg::M_TDATA_W-1:0]  out_data_reg, out_data_next;

    // Misc.
    logic                            s_accept;
    logic                            out_free;
    logic [LCW-1:0]                  wl_ext;
    logic [CW-1:0]                   eff_len;
    logic                            evict_needed;
    logic                            result_due;
    logic                            div_start;
    logic                            div_busy;
    logic                            task_busy, resp_busy, alt_busy;
    logic signed [wrbm_pkg::TASK_MEAN_W-1:0] task_q;
    logic signed [wrbm_pkg::RESP_MEAN_W-1:0] resp_q;
    logic signed [wrbm_pkg::ALT_MEAN_W-1:0]  alt_q;
    logic signed [SS_W-1:0]          sv_new, sv_old;
    logic signed [RS_W-1:0]          rv_new, rv_old;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Effective window length: zero acts as one, large values clip.
    assign wl_ext  = LCW'(win_len_reg);
    assign eff_len = (win_len_reg == '0) ? CW'(1) :
                     (wl_ext > LCW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : wl_ext[CW-1:0];

    assign evict_needed = (fill_reg >= eff_len);
    assign result_due   = (count_reg >= grace_reg) &&
                          (count_reg >= wrbm_pkg::COUNT_W'(eff_len));

    // Signed values of the new and the evicted entry; zero counts as -1.
    assign sv_new = flag_reg ? SS_W'(1) : '1;
    assign rv_new = (choice_reg == '0) ? '1 : RS_W'(choice_reg);
    assign sv_old = rd_data_reg[0] ? SS_W'(1) : '1;
    assign rv_old = (rd_data_reg[ENT_W-1:1] == '0) ? '1 : RS_W'(rd_data_reg[ENT_W-1:1]);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= wrbm_pkg::WIN_LEN_RST;
            grace_reg   <= wrbm_pkg::GRACE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wrbm_pkg::REG_WINDOW_LENGTH: win_len_reg <= cfg_wdata[wrbm_pkg::WIN_LEN_W-1:0];
                wrbm_pkg::REG_GRACE_TRIALS:  grace_reg   <= cfg_wdata[wrbm_pkg::GRACE_W-1:0];
            endcase
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrbm_pkg::ST_IDLE:
            begin
                if (s_accept && (s_tuser[0] == wrbm_pkg::CMD_TRIAL))
                begin
                    state_next = wrbm_pkg::ST_CHECK;
                end
            end
            wrbm_pkg::ST_CHECK:
            begin
                state_next = evict_needed ? wrbm_pkg::ST_EVICT : wrbm_pkg::ST_THRESH;
            end
            wrbm_pkg::ST_EVICT:
            begin
                state_next = wrbm_pkg::ST_CHECK;
            end
            wrbm_pkg::ST_THRESH:
            begin
                state_next = result_due ? wrbm_pkg::ST_DIV : wrbm_pkg::ST_IDLE;
            end
            wrbm_pkg::ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    state_next = wrbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrbm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        oldest_next    = oldest_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        ssum_next      = ssum_reg;
        rsum_next      = rsum_reg;
        asum_next      = asum_reg;
        flag_next      = flag_reg;
        choice_next    = choice_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        div_start      = 1'b0;
        s_tready       = 1'b0;
        unique case (state_reg)
            wrbm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_accept)
                begin
                    if (s_tuser[0] == wrbm_pkg::CMD_CLEAR)
                    begin
                        oldest_next = '0;
                        wr_ptr_next = '0;
                        fill_next   = '0;
                        count_next  = '0;
                        ssum_next   = '0;
                        rsum_next   = '0;
                        asum_next   = '0;
                    end
                    else
                    begin
                        flag_next   = s_tdata[0];
                        choice_next = s_tdata[wrbm_pkg::CHOICE_W:1];
                        if (count_reg != '1)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            wrbm_pkg::ST_CHECK:
            begin
                if (evict_needed)
                begin
                    // Fetch the oldest entry for removal.
                    mem_re = 1'b1;
                end
                else
                begin
                    // Append the new entry; its sign follows its position.
                    mem_we      = 1'b1;
                    ssum_next   = ssum_reg + sv_new;
                    rsum_next   = rsum_reg + rv_new;
                    asum_next   = fill_reg[0] ? (asum_reg - rv_new) : (asum_reg + rv_new);
                    wr_ptr_next = (wr_ptr_reg == AW'(WINDOW_MAX - 1)) ? '0 : wr_ptr_reg + 1'b1;
                    fill_next   = fill_reg + 1'b1;
                end
            end
            wrbm_pkg::ST_EVICT:
            begin
                // Removing the oldest entry flips every remaining sign.
                ssum_next   = ssum_reg - sv_old;
                rsum_next   = rsum_reg - rv_old;
                asum_next   = rv_old - asum_reg;
                oldest_next = (oldest_reg == AW'(WINDOW_MAX - 1)) ? '0 : oldest_reg + 1'b1;
                fill_next   = fill_reg - 1'b1;
            end
            wrbm_pkg::ST_THRESH:
            begin
                div_start = result_due;
            end
            wrbm_pkg::ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{wrbm_pkg::M_PAD_W{1'b0}}, alt_q, resp_q, task_q};
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrbm_pkg::ST_IDLE;
            oldest_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            ssum_reg      <= '0;
            rsum_reg      <= '0;
            asum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            ssum_reg      <= ssum_next;
            rsum_reg      <= rsum_next;
            asum_reg      <= asum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        flag_reg     <= flag_next;
        choice_reg   <= choice_next;
        out_data_reg <= out_data_next;
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[wr_ptr_reg] <= {choice_reg, flag_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= win_mem[oldest_reg];
        end
    end

    // Three bit-serial divider lanes started together.
    wrbm_div_lane #(
        .MAG_W (CW),
        .LEN_W (CW),
        .Q_W   (wrbm_pkg::TASK_MEAN_W)
    ) u_task_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .len      (eff_len),
        .sum      (ssum_reg),
        .busy     (task_busy),
        .quotient (task_q)
    );

    wrbm_div_lane #(
        .MAG_W (CW + wrbm_pkg::CHOICE_W),
        .LEN_W (CW),
        .Q_W   (wrbm_pkg::RESP_MEAN_W)
    ) u_resp_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .len      (eff_len),
        .sum      (rsum_reg),
        .busy     (resp_busy),
        .quotient (resp_q)
    );

    wrbm_div_lane #(
        .MAG_W (CW + wrbm_pkg::CHOICE_W),
        .LEN_W (CW),
        .Q_W   (wrbm_pkg::ALT_MEAN_W)
    ) u_alt_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .len      (eff_len),
        .sum      (asum_reg),
        .busy     (alt_busy),
        .quotient (alt_q)
    );

    assign div_busy = task_busy || resp_busy || alt_busy;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/wrbm_checker.sv
// ----------------------------------------------------------------------------
// Windowed response bias monitor checker
// Port-level assertions on the stream handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "windowed_response_bias_monitor_macros.svh"

module wrbm_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [wrbm_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [wrbm_pkg::M_TDATA_W-1:0]      m_tdata
);

    // A trial occupies the block, so the next transaction must wait.
    `WRBM_ASSERT_NXT(a_trial_blocks, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == wrbm_pkg::CMD_TRIAL), !s_tready, "input ready right after a trial")

    // A clear completes and leaves the block ready in the next cycle.
    `WRBM_ASSERT_NXT(a_clear_ready, clk, rst_n, s_tvalid && s_tready && (s_tuser[0] == wrbm_pkg::CMD_CLEAR), s_tready, "input not ready after a clear")

    // A result held back by the sink stays offered.
    `WRBM_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "output valid dropped while stalled")

    // A stalled result keeps its value.
    `WRBM_ASSERT_NXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "output data changed while stalled")

endmodule

bind windowed_response_bias_monitor wrbm_checker u_wrbm_checker (.*);

FILE: bench/tb_windowed_response_bias_monitor.sv
// ----------------------------------------------------------------------------
// Windowed response bias monitor testbench
// Drives trial and clear transactions into the input stream and configures
// the window length and grace count through the write port. Every result
// is matched against an in-bench model of the sliding window or a known
// value. The run starts with a short directed sequence of boundary cases.
// Random phases follow, covering several register settings, random idle
// gaps on both streams, a long output back-pressure stretch and a grace
// count that is never reached.
// ----------------------------------------------------------------------------
module tb_windowed_response_bias_monitor;

    localparam int          DEPTH        = 64;
    localparam int unsigned COUNT_MAX    = 65535;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned CYCLE_LIMIT  = 3000000;
    localparam int          PRINT_LIMIT  = 50;
    localparam int unsigned OWED_DEPTH   = 8;
    localparam int          ROW_MAX      = 40;

    // One result: the three means as they sit in m_tdata.
    typedef struct packed {
        logic [wrbm_pkg::ALT_MEAN_W-1:0]  alternation_mean;
        logic [wrbm_pkg::RESP_MEAN_W-1:0] response_mean;
        logic [wrbm_pkg::TASK_MEAN_W-1:0] task_mean;
    } means_t;

    // One row of the directed sequence: a register write or a transaction.
    typedef struct {
        bit                               is_write;
        logic [wrbm_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [wrbm_pkg::CFG_DATA_W-1:0]  reg_value;
        logic                             command;
        logic                             success;
        logic [wrbm_pkg::CHOICE_W-1:0]    choice;
        bit                               known;
        means_t                           known_means;
    } stim_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [wrbm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wrbm_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [wrbm_pkg::S_TDATA_W-1:0]   s_tdata;
    logic [wrbm_pkg::S_TUSER_W-1:0]   s_tuser;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [wrbm_pkg::M_TDATA_W-1:0]   m_tdata;

    // Shadow copy of the registers and the window contents.
    logic [wrbm_pkg::WIN_LEN_W-1:0]   win_len_shadow;
    logic [wrbm_pkg::GRACE_W-1:0]     grace_shadow;
    logic                             success_hist [DEPTH];
    logic [wrbm_pkg::CHOICE_W-1:0]    choice_hist [DEPTH];
    int unsigned                      oldest_slot;
    int unsigned                      held_trials;
    int unsigned                      trials_seen;

    // Results owed by the block, written by the sender and read by the
    // receiver, each side with its own counter.
    means_t                           owed_means [OWED_DEPTH];
    int unsigned                      owed_wr = 0;
    int unsigned                      owed_rd = 0;
    stim_row_t                        directed_rows [ROW_MAX];
    int                               row_count = 0;
    int                               error_count;
    bit                               tx_idle_on;
    logic                             rx_idle_on = 1'b1;
    int unsigned                      hold_tokens = 0;
    int unsigned                      hold_taken = 0;
    int unsigned                      hold_left = 0;
    int unsigned                      stall_left = 0;

    windowed_response_bias_monitor #(
        .WINDOW_MAX (DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10-unit clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mismatch reporting: print one line and count it.
    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 80);
    endfunction

    // Sum times 2^16 over the length, truncated toward zero.
    function automatic logic [31:0] scaled_mean(input int sum, input int unsigned len);
        longint quotient;
        quotient = (longint'(sum) * 65536) / longint'(len);
        return quotient[31:0];
    endfunction

    // Window model: applies one accepted transaction and tells whether a
    // result is due and what it holds.
    task automatic window_trial(input logic command, input logic success,
                                input logic [wrbm_pkg::CHOICE_W-1:0] choice,
                                output bit emits, output means_t means);
        int unsigned span;
        int unsigned slot;
        int unsigned idx;
        int unsigned threshold;
        int          s_sum;
        int          r_sum;
        int          a_sum;
        int          value;
        logic [31:0] q;
        emits = 1'b0;
        means = '0;
        if (win_len_shadow == 0)
            span = 1;
        else if (win_len_shadow > DEPTH)
            span = DEPTH;
        else
            span = 32'(win_len_shadow);

        if (command == wrbm_pkg::CMD_CLEAR)
        begin
            oldest_slot = 0;
            held_trials = 0;
            trials_seen = 0;
        end
        else
        begin
            if (trials_seen < COUNT_MAX)
                trials_seen++;
            // Drop the oldest entries until the new one fits.
            while (held_trials >= span)
            begin
                oldest_slot = (oldest_slot + 1) % DEPTH;
                held_trials--;
            end
            slot = (oldest_slot + held_trials) % DEPTH;
            success_hist[slot] = success;
            choice_hist[slot] = choice;
            held_trials++;

            // Zero counts as -1; the alternating sign is + at the oldest entry.
            s_sum = 0;
            r_sum = 0;
            a_sum = 0;
            for (int unsigned i = 0; i < held_trials; i++)
            begin
                idx = (oldest_slot + i) % DEPTH;
                s_sum += success_hist[idx] ? 1 : -1;
                value = (choice_hist[idx] == 0) ? -1 : int'(choice_hist[idx]);
                r_sum += value;
                a_sum += (i % 2 == 0) ? value : -value;
            end

            threshold = (32'(grace_shadow) > span) ? 32'(grace_shadow) : span;
            if (trials_seen >= threshold)
            begin
                emits = 1'b1;
                q = scaled_mean(s_sum, span);
                means.task_mean = q[wrbm_pkg::TASK_MEAN_W-1:0];
                q = scaled_mean(r_sum, span);
                means.response_mean = q[wrbm_pkg::RESP_MEAN_W-1:0];
                q = scaled_mean(a_sum, span);
                means.alternation_mean = q[wrbm_pkg::ALT_MEAN_W-1:0];
            end
        end
    endtask

    // Offer one transaction, wait for the handshake, then record what the
    // block owes for it.
    task automatic offer_item(input logic command, input logic success,
                              input logic [wrbm_pkg::CHOICE_W-1:0] choice,
                              input bit known, input means_t known_means);
        int unsigned gap;
        bit          emits;
        means_t      predicted;
        gap = tx_idle_on ? idle_length() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(wrbm_pkg::S_TDATA_W-wrbm_pkg::CHOICE_W-1){1'b0}}, choice, success};
        s_tuser  <= command;
        do @(posedge clk); while (s_tready !== 1'b1);
        window_trial(command, success, choice, emits, predicted);
        if (emits)
        begin
            owed_means[owed_wr % OWED_DEPTH] = known ? known_means : predicted;
            owed_wr++;
        end
    endtask

    // Random transaction; response 0 and 255 are favored.
    task automatic random_item(input int unsigned clear_pct);
        logic                          command;
        logic [wrbm_pkg::CHOICE_W-1:0] choice;
        logic [31:0]                   raw;
        int unsigned                   pick;
        command = ($urandom_range(0, 99) < clear_pct) ? wrbm_pkg::CMD_CLEAR
                                                      : wrbm_pkg::CMD_TRIAL;
        raw = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            choice = '0;
        else if (pick < 3)
            choice = '1;
        else
            choice = raw[wrbm_pkg::CHOICE_W:1];
        offer_item(command, raw[0], choice, 1'b0, '0);
    endtask

    // Stop offering and let every owed result come out, then let the block
    // finish any trial that owes nothing.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (owed_wr != owed_rd)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wrbm_pkg::CFG_INDEX_W-1:0] index,
                             input logic [wrbm_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (index == wrbm_pkg::REG_WINDOW_LENGTH)
            win_len_shadow = value[wrbm_pkg::WIN_LEN_W-1:0];
        else
            grace_shadow = value[wrbm_pkg::GRACE_W-1:0];
    endtask

    // One random phase under a fresh register setting.
    task automatic run_phase(input logic [wrbm_pkg::CFG_DATA_W-1:0] len_value,
                             input logic [wrbm_pkg::CFG_DATA_W-1:0] grace_value,
                             input bit clear_first, input int unsigned items,
                             input int unsigned clear_pct, input bit idle,
                             input bit hold);
        logic [31:0] raw;
        settle_idle();
        write_reg(wrbm_pkg::REG_WINDOW_LENGTH, len_value);
        write_reg(wrbm_pkg::REG_GRACE_TRIALS, grace_value);
        tx_idle_on = idle;
        rx_idle_on <= idle;
        if (hold)
            hold_tokens <= hold_tokens + 1;
        if (clear_first)
        begin
            raw = $urandom;
            offer_item(wrbm_pkg::CMD_CLEAR, raw[0], raw[wrbm_pkg::CHOICE_W:1], 1'b0, '0);
        end
        repeat (items) random_item(clear_pct);
    endtask

    // Directed table builders.
    task automatic add_write(input logic [wrbm_pkg::CFG_INDEX_W-1:0] index,
                             input logic [wrbm_pkg::CFG_DATA_W-1:0] value);
        stim_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        directed_rows[row_count] = row;
        row_count++;
    endtask

    task automatic add_item(input logic command, input logic success,
                            input logic [wrbm_pkg::CHOICE_W-1:0] choice);
        stim_row_t row;
        row = '{default: '0};
        row.command = command;
        row.success = success;
        row.choice = choice;
        directed_rows[row_count] = row;
        row_count++;
    endtask

    task automatic add_known(input logic success,
                             input logic [wrbm_pkg::CHOICE_W-1:0] choice,
                             input logic [wrbm_pkg::TASK_MEAN_W-1:0] task_mean,
                             input logic [wrbm_pkg::RESP_MEAN_W-1:0] response_mean,
                             input logic [wrbm_pkg::ALT_MEAN_W-1:0] alternation_mean);
        stim_row_t row;
        row = '{default: '0};
        row.command = wrbm_pkg::CMD_TRIAL;
        row.success = success;
        row.choice = choice;
        row.known = 1'b1;
        row.known_means = '{alternation_mean, response_mean, task_mean};
        directed_rows[row_count] = row;
        row_count++;
    endtask

    // Output side: check each result transaction and drive m_tready with
    // random stalls plus the occasional long hold.
    always @(posedge clk)
    begin : result_side
        means_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                if (owed_wr == owed_rd)
                begin
                    report_error($sformatf("result with no expectation waiting: %h",
                                 m_tdata));
                end
                else
                begin
                    want = owed_means[owed_rd % OWED_DEPTH];
                    owed_rd++;
                    if (m_tdata[wrbm_pkg::TASK_MEAN_W-1:0] !== want.task_mean)
                        report_error($sformatf("task_mean got %h want %h",
                                     m_tdata[wrbm_pkg::TASK_MEAN_W-1:0], want.task_mean));
                    if (m_tdata[wrbm_pkg::TASK_MEAN_W +: wrbm_pkg::RESP_MEAN_W]
                        !== want.response_mean)
                        report_error($sformatf("response_mean got %h want %h",
                                     m_tdata[wrbm_pkg::TASK_MEAN_W +: wrbm_pkg::RESP_MEAN_W],
                                     want.response_mean));
                    if (m_tdata[wrbm_pkg::TASK_MEAN_W+wrbm_pkg::RESP_MEAN_W +:
                                wrbm_pkg::ALT_MEAN_W] !== want.alternation_mean)
                        report_error($sformatf("alternation_mean got %h want %h",
                                     m_tdata[wrbm_pkg::TASK_MEAN_W+wrbm_pkg::RESP_MEAN_W +:
                                             wrbm_pkg::ALT_MEAN_W],
                                     want.alternation_mean));
                    if (m_tdata[wrbm_pkg::M_TDATA_W-1 -: wrbm_pkg::M_PAD_W] !== '0)
                        report_error($sformatf("padding bits got %h",
                                     m_tdata[wrbm_pkg::M_TDATA_W-1 -: wrbm_pkg::M_PAD_W]));
                end
            end

            if (hold_tokens != hold_taken)
            begin
                hold_taken = hold_tokens;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
                hold_left--;
            else if (stall_left != 0)
                stall_left--;
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
                stall_left = idle_length();
            m_tready <= (hold_left == 0) && (stall_left == 0);
        end
    end

    // Run limit.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_windowed_response_bias_monitor failed");
        $finish;
    end

    initial
    begin : stimulus
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        error_count = 0;
        tx_idle_on = 1'b1;
        win_len_shadow = wrbm_pkg::WIN_LEN_RST;
        grace_shadow = wrbm_pkg::GRACE_RST;
        oldest_slot = 0;
        held_trials = 0;
        trials_seen = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: no result before the grace count, clear ignores data.
        add_item(wrbm_pkg::CMD_TRIAL, 1'b1, 8'd255);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b0, 8'd0);
        add_item(wrbm_pkg::CMD_CLEAR, 1'b1, 8'd255);
        // Single-entry window, no grace: each mean is the value itself.
        add_write(wrbm_pkg::REG_WINDOW_LENGTH, 16'd1);
        add_write(wrbm_pkg::REG_GRACE_TRIALS, 16'd0);
        add_known(1'b1, 8'd255, 18'h10000, 25'h0FF0000, 25'h0FF0000);
        add_known(1'b0, 8'd0, 18'h30000, 25'h1FF0000, 25'h1FF0000);
        add_known(1'b1, 8'd1, 18'h10000, 25'h0010000, 25'h0010000);
        add_known(1'b0, 8'd128, 18'h30000, 25'h0800000, 25'h0800000);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b1, 8'h55);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b0, 8'hAA);
        add_item(wrbm_pkg::CMD_CLEAR, 1'b0, 8'd0);
        add_known(1'b1, 8'd7, 18'h10000, 25'h0070000, 25'h0070000);
        // Length zero acts as one.
        add_write(wrbm_pkg::REG_WINDOW_LENGTH, 16'd0);
        add_known(1'b0, 8'd255, 18'h30000, 25'h0FF0000, 25'h0FF0000);
        // Window raised: sums over fewer entries, still divided by three.
        add_write(wrbm_pkg::REG_WINDOW_LENGTH, 16'd3);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b1, 8'd0);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b0, 8'd200);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b1, 8'd3);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b1, 8'd0);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b0, 8'd254);
        // Window lowered while full: two entries drop at once.
        add_write(wrbm_pkg::REG_WINDOW_LENGTH, 16'd2);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b0, 8'd9);
        add_item(wrbm_pkg::CMD_TRIAL, 1'b1, 8'd255);
        // Grace longer than the window.
        add_write(wrbm_pkg::REG_GRACE_TRIALS, 16'd5);
        add_item(wrbm_pkg::CMD_CLEAR, 1'b1, 8'd1);
        repeat (5) add_item(wrbm_pkg::CMD_TRIAL, 1'b1, 8'd100);

        for (int i = 0; i < row_count; i++)
        begin
            if (directed_rows[i].is_write)
            begin
                settle_idle();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
            begin
                offer_item(directed_rows[i].command, directed_rows[i].success,
                           directed_rows[i].choice, directed_rows[i].known,
                           directed_rows[i].known_means);
            end
        end

        // Random phases: length, grace, clear first, items, clear percent,
        // idle gaps, long output hold.
        run_phase(16'd16, 16'd16, 1'b1, 120, 2, 1'b1, 1'b0);
        run_phase(16'd1, 16'd0, 1'b0, 100, 2, 1'b0, 1'b1);
        run_phase(16'd64, 16'd0, 1'b0, 150, 1, 1'b1, 1'b0);
        run_phase(16'hFF85, 16'd0, 1'b0, 80, 2, 1'b1, 1'b0);
        run_phase(16'd127, 16'd3, 1'b0, 90, 1, 1'b1, 1'b0);
        run_phase(16'd0, 16'd70, 1'b1, 120, 0, 1'b1, 1'b0);
        run_phase(16'd33, 16'd40, 1'b1, 100, 2, 1'b0, 1'b0);

        // Largest grace: the count is never reached, so nothing comes out.
        run_phase(16'd64, 16'hFFFF, 1'b1, 40, 0, 1'b0, 1'b0);
        run_phase(16'd7, 16'hFFFF, 1'b0, 40, 0, 1'b1, 1'b0);
        run_phase(16'd2, 16'd1, 1'b1, 60, 3, 1'b1, 1'b0);

        settle_idle();
        if (error_count == 0)
            $display("tb_windowed_response_bias_monitor passed");
        else
            $display("tb_windowed_response_bias_monitor failed");
        $finish;
    end

endmodule

FILE: windowed_response_bias_monitor.f
+incdir+rtl
rtl/wrbm_pkg.sv
rtl/wrbm_div_lane.sv
rtl/windowed_response_bias_monitor.sv
rtl/wrbm_checker.sv
bench/tb_windowed_response_bias_monitor.sv
